@@ hdl/http_message_byte_parser_macros.svh @@
// Assertion helpers for the HTTP message byte parser.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef HTTP_MESSAGE_BYTE_PARSER_MACROS_SVH
`define HTTP_MESSAGE_BYTE_PARSER_MACROS_SVH
`ifndef SYNTH
`define HMBP_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define HMBP_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HMBP_ASSERT_SAME(label, ante, cons, msg)
`define HMBP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ hdl/hmbp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmbp_pkg
// Types, codes and constant name tables for the HTTP message byte parser.
// ---------------------------------------------------------------------------
package hmbp_pkg;

	localparam int MAX_HEADERS = 32;
	localparam int LEN_W       = 32;
	localparam int CNT_W       = 9;
	localparam logic [31:0] CAP_RESET = 32'd65536;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] LOWER_OFS = 8'd32;

	localparam logic [4:0] LEN_NAME_LEN = 5'd14;
	localparam logic [4:0] ENC_NAME_LEN = 5'd17;
	localparam logic [2:0] CHUNKED_LEN  = 3'd7;

	typedef enum logic [3:0] {
		KIND_DELIM  = 4'd0,
		KIND_METHOD = 4'd1,
		KIND_TARGET = 4'd2,
		KIND_VER    = 4'd3,
		KIND_KEY    = 4'd4,
		KIND_VALUE  = 4'd5,
		KIND_BODY   = 4'd6,
		KIND_CSIZE  = 4'd7,
		KIND_CEXT   = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		ST_BUSY  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		PH_LSTART, PH_METHOD, PH_PRE_TARGET, PH_TARGET, PH_PRE_VER, PH_VER,
		PH_LINE_LF, PH_HSTART, PH_KEY, PH_PRE_VAL, PH_VAL, PH_HDR_LF, PH_END_LF,
		PH_BODY, PH_CSIZE_START, PH_CSIZE, PH_CEXT, PH_CSIZE_LF, PH_CDATA,
		PH_CDATA_CR, PH_CDATA_LF
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0] value;
		logic             bad;
	} acc_t;

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SP;
	endfunction

	// "content-length", one character per index
	function automatic logic [7:0] len_name_char(input logic [4:0] i);
		unique case (i)
			5'd0:  return "c";
			5'd1:  return "o";
			5'd2:  return "n";
			5'd3:  return "t";
			5'd4:  return "e";
			5'd5:  return "n";
			5'd6:  return "t";
			5'd7:  return "-";
			5'd8:  return "l";
			5'd9:  return "e";
			5'd10: return "n";
			5'd11: return "g";
			5'd12: return "t";
			5'd13: return "h";
			default: return 8'h00;
		endcase
	endfunction

	// "transfer-encoding"
	function automatic logic [7:0] enc_name_char(input logic [4:0] i);
		unique case (i)
			5'd0:  return "t";
			5'd1:  return "r";
			5'd2:  return "a";
			5'd3:  return "n";
			5'd4:  return "s";
			5'd5:  return "f";
			5'd6:  return "e";
			5'd7:  return "r";
			5'd8:  return "-";
			5'd9:  return "e";
			5'd10: return "n";
			5'd11: return "c";
			5'd12: return "o";
			5'd13: return "d";
			5'd14: return "i";
			5'd15: return "n";
			5'd16: return "g";
			default: return 8'h00;
		endcase
	endfunction

	// "chunked"
	function automatic logic [7:0] chunked_char(input logic [2:0] i);
		unique case (i)
			3'd0: return "c";
			3'd1: return "h";
			3'd2: return "u";
			3'd3: return "n";
			3'd4: return "k";
			3'd5: return "e";
			3'd6: return "d";
			default: return 8'h00;
		endcase
	endfunction

	// Hex digit value, 16 for anything else
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] d;
		d = 5'd16;
		if (c >= "0" && c <= "9") d = 5'(c - 8'h30);
		else if (c >= "A" && c <= "F") d = 5'(c - 8'h37);
		else if (c >= "a" && c <= "f") d = 5'(c - 8'h57);
		return d;
	endfunction

	// Decimal digit value, 10 for anything else
	function automatic logic [4:0] dec_digit(input logic [7:0] c);
		return (c >= "0" && c <= "9") ? 5'(c - 8'h30) : 5'd10;
	endfunction

	// Shift one digit into the length; flag bad digits and overflow
	function automatic acc_t accumulate(input acc_t a, input logic hex, input logic [4:0] d);
		acc_t r;
		logic [LEN_W+4:0] prod;
		r = a;
		prod = hex ? {1'b0, a.value, 4'b0000}
		           : ({5'b0, a.value} << 3) + ({5'b0, a.value} << 1);
		prod = prod + {{(LEN_W+1){1'b0}}, d[3:0]};
		if (!a.bad) begin
			if (d >= (hex ? 5'd16 : 5'd10) || prod[LEN_W+4:LEN_W] != '0) r.bad = 1'b1;
			else r.value = prod[LEN_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/hmbp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hmbp_if
// Stream channels of the parser: message bytes in, tagged words out, and
// the capacity register write channel.
// ---------------------------------------------------------------------------
interface hmbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_message;
	modport source (output valid, data_byte, new_message, input ready);
	modport sink   (input valid, data_byte, new_message, output ready);
endinterface

interface hmbp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  tagged_byte;
	logic [3:0]  token_kind;
	logic        token_start;
	logic [1:0]  parse_status;
	logic [31:0] body_length;
	modport source (output valid, tagged_byte, token_kind, token_start, parse_status,
		body_length, input ready);
	modport sink   (input valid, tagged_byte, token_kind, token_start, parse_status,
		body_length, output ready);
endinterface

interface hmbp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

@@ hdl/http_message_byte_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_message_byte_parser
// Tags each byte of an HTTP/1.1 request with its token kind, tracks header
// names, the declared body length and one chunk, and flags protocol errors.
// ---------------------------------------------------------------------------
// channel  dir  payload
// rx       in   data_byte[8], new_message[1]
// tx       out  tagged_byte[8], token_kind[4], token_start, parse_status[2],
//               body_length[32]
// cfg      in   data[32] -> buffer_capacity
//
// One byte per cycle while the result register is empty or being taken; each
// result word is registered and appears in the cycle after its byte.
// rx is ready whenever the result register is empty or being taken.
// cfg is always ready. Reset restores capacity 65536 and the request-line
// state; no clearing pass.
`include "http_message_byte_parser_macros.svh"

module http_message_byte_parser
	import hmbp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	hmbp_in_if.sink    rx,
	hmbp_out_if.source tx,
	hmbp_cfg_if.sink   cfg
);

	phase_t           phase_q, ph;
	logic [31:0]      cap_q;
	logic [31:0]      pos_q, pos;
	logic [CNT_W-1:0] hdr_q, hdr;
	logic [4:0]       kidx_q, kidx;
	logic [1:0]       kflg_q, kflg;
	logic [2:0]       seen_q, seen;
	logic [3:0]       chm_q, chm;
	logic [LEN_W-1:0] len_q, len;
	logic [LEN_W-1:0] rem_q, rem;
	logic             error_q, err;

	logic [7:0]       c, tb;
	kind_t            kind;
	logic             start, fail, done;
	status_t          status;
	logic [31:0]      blen;
	logic             cr, lf;
	acc_t             acc;
	logic [4:0]       ki;
	logic [2:0]       ci;
	logic [32:0]      used;
	logic             accept;

	assign accept    = rx.valid && rx.ready;
	assign rx.ready  = !tx.valid || tx.ready;
	assign cfg.ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// next parse state and result word
	always_comb begin
		c = rx.data_byte;
		cr = c == CH_CR;
		lf = c == CH_LF;
		ph = phase_q; pos = pos_q; hdr = hdr_q; kidx = kidx_q; kflg = kflg_q;
		seen = seen_q; chm = chm_q; len = len_q; rem = rem_q; err = error_q;
		tb = c; kind = KIND_DELIM; start = 1'b0; status = ST_BUSY; blen = '0;
		fail = 1'b0; done = 1'b0;
		acc = '0; ki = '0; ci = '0; used = '0;
		if (rx.new_message) begin
			ph = PH_LSTART; pos = '0; hdr = '0; kidx = '0; kflg = 2'b11;
			seen = '0; chm = '0; len = '0; rem = '0; err = 1'b0;
		end
		if (err) begin
			status = ST_ERROR;
		end else begin
			if (pos != 32'hFFFF_FFFF) pos = pos + 32'd1;
			unique case (ph)
				PH_LSTART, PH_PRE_TARGET: begin
					if (is_ws(c)) begin
					end else if (cr || lf) fail = 1'b1;
					else begin
						start = 1'b1;
						kind = (ph == PH_LSTART) ? KIND_METHOD : KIND_TARGET;
						ph = (ph == PH_LSTART) ? PH_METHOD : PH_TARGET;
					end
				end
				PH_METHOD, PH_TARGET: begin
					if (cr || lf) fail = 1'b1;
					else if (is_ws(c)) ph = (ph == PH_METHOD) ? PH_PRE_TARGET : PH_PRE_VER;
					else kind = (ph == PH_METHOD) ? KIND_METHOD : KIND_TARGET;
				end
				PH_PRE_VER, PH_VER: begin
					if (ph == PH_PRE_VER && is_ws(c)) begin
					end else if (lf) fail = 1'b1;
					else if (cr) ph = PH_LINE_LF;
					else begin
						start = ph == PH_PRE_VER;
						kind = KIND_VER;
						ph = PH_VER;
					end
				end
				PH_LINE_LF: begin
					if (!lf) fail = 1'b1;
					else ph = PH_HSTART;
				end
				PH_HSTART, PH_KEY: begin
					if (ph == PH_HSTART && is_ws(c)) begin
					end else if (ph == PH_HSTART && cr) ph = PH_END_LF;
					else if (lf || (ph == PH_KEY && cr)) fail = 1'b1;
					else begin
						if (ph == PH_HSTART) begin
							kidx = '0;
							kflg = 2'b11;
						end
						if (c == CH_COLON) begin
							// close the key: keep only first-seen full name matches
							kflg = {kflg[1] && kidx == ENC_NAME_LEN && !seen[1],
								kflg[0] && kidx == LEN_NAME_LEN && !seen[0]};
							ph = PH_PRE_VAL;
						end else begin
							if (c >= CH_UP_A && c <= CH_UP_Z) tb = c + LOWER_OFS;
							ki = kidx;
							if (ki >= LEN_NAME_LEN || tb != len_name_char(ki)) kflg[0] = 1'b0;
							if (ki >= ENC_NAME_LEN || tb != enc_name_char(ki)) kflg[1] = 1'b0;
							if (kidx != 5'd31) kidx = kidx + 5'd1;
							kind = KIND_KEY;
							start = ph == PH_HSTART;
							ph = PH_KEY;
						end
					end
				end
				PH_PRE_VAL, PH_VAL: begin
					if (ph == PH_PRE_VAL && is_ws(c)) begin
					end else if (lf) fail = 1'b1;
					else if (cr) ph = PH_HDR_LF;
					else begin
						if (kflg[0]) begin
							acc = accumulate('{value: len, bad: seen[2]}, 1'b0, dec_digit(c));
							len = acc.value;
							seen[2] = acc.bad;
						end
						if (kflg[1]) begin
							ci = chm[2:0];
							if (ci < CHUNKED_LEN) begin
								chm = {chm[3] || c != chunked_char(ci), ci + 3'd1};
							end
						end
						kind = KIND_VALUE;
						start = ph == PH_PRE_VAL;
						ph = PH_VAL;
					end
				end
				PH_HDR_LF: begin
					if (!lf || hdr >= CNT_W'(MAX_HEADERS)) fail = 1'b1;
					else begin
						hdr = hdr + 1'b1;
						seen[1:0] = seen[1:0] | kflg;
						kflg = 2'b11;
						kidx = '0;
						ph = PH_HSTART;
					end
				end
				PH_END_LF: begin
					used = {1'b0, pos} + {1'b0, len};
					if (!lf) fail = 1'b1;
					else if (seen[0]) begin
						if (seen[2] || len > cap_q || used > {1'b0, cap_q}) fail = 1'b1;
						else if (len == '0) done = 1'b1;
						else begin
							rem = len;
							ph = PH_BODY;
						end
					end else if (seen[1]) begin
						if (chm[3]) fail = 1'b1;
						else begin
							len = '0;
							seen[2] = 1'b0;
							ph = PH_CSIZE_START;
						end
					end else done = 1'b1;
				end
				PH_BODY, PH_CDATA: begin
					kind = KIND_BODY;
					start = rem == len;
					if (rem != '0) rem = rem - 1'b1;
					if (rem == '0) begin
						if (ph == PH_BODY) begin
							blen = len;
							done = 1'b1;
						end else ph = PH_CDATA_CR;
					end
				end
				PH_CSIZE_START: begin
					if (is_ws(c) || cr || lf || c == CH_SEMI) fail = 1'b1;
					else begin
						acc = accumulate('{value: len, bad: seen[2]}, 1'b1, hex_digit(c));
						len = acc.value;
						seen[2] = acc.bad;
						kind = KIND_CSIZE;
						start = 1'b1;
						ph = PH_CSIZE;
					end
				end
				PH_CSIZE: begin
					if (lf) fail = 1'b1;
					else if (cr) ph = PH_CSIZE_LF;
					else if (is_ws(c) || c == CH_SEMI) begin
						kind = KIND_CEXT;
						start = 1'b1;
						ph = PH_CEXT;
					end else begin
						acc = accumulate('{value: len, bad: seen[2]}, 1'b1, hex_digit(c));
						len = acc.value;
						seen[2] = acc.bad;
						kind = KIND_CSIZE;
					end
				end
				PH_CEXT: begin
					if (lf) fail = 1'b1;
					else if (cr) ph = PH_CSIZE_LF;
					else kind = KIND_CEXT;
				end
				PH_CSIZE_LF: begin
					if (!lf || seen[2]) fail = 1'b1;
					else begin
						rem = len;
						ph = (len == '0) ? PH_CDATA_CR : PH_CDATA;
					end
				end
				PH_CDATA_CR: begin
					if (!cr) fail = 1'b1;
					else ph = PH_CDATA_LF;
				end
				PH_CDATA_LF: begin
					if (!lf) fail = 1'b1;
					else begin
						blen = len;
						done = 1'b1;
					end
				end
				default: fail = 1'b1;
			endcase
			// settle status and reported length
			if (fail) begin
				err = 1'b1;
				status = ST_ERROR;
				kind = KIND_DELIM;
				start = 1'b0;
				blen = '0;
				tb = c;
			end else if (done) begin
				status = ST_DONE;
				ph = PH_LSTART; pos = '0; hdr = '0; kidx = '0; kflg = 2'b11;
				seen = '0; chm = '0; len = '0; rem = '0;
			end else if (ph == PH_BODY || ph == PH_CDATA || ph == PH_CDATA_CR ||
				ph == PH_CDATA_LF) begin
				blen = len;
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LSTART;
			pos_q   <= '0;
			hdr_q   <= '0;
			kidx_q  <= '0;
			kflg_q  <= 2'b11;
			seen_q  <= '0;
			chm_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			error_q <= 1'b0;
		end else if (accept) begin
			phase_q <= ph;
			pos_q   <= pos;
			hdr_q   <= hdr;
			kidx_q  <= kidx;
			kflg_q  <= kflg;
			seen_q  <= seen;
			chm_q   <= chm;
			len_q   <= len;
			rem_q   <= rem;
			error_q <= err;
		end
	end

	// result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx.valid <= 1'b0;
		end else if (accept) begin
			tx.valid <= 1'b1;
		end else if (tx.ready) begin
			tx.valid <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tx.tagged_byte  <= tb;
			tx.token_kind   <= kind;
			tx.token_start  <= start;
			tx.parse_status <= status;
			tx.body_length  <= blen;
		end
	end

	`HMBP_ASSERT_NEXT(a_err_sticky, error_q && !(accept && rx.new_message), error_q, "error cleared without new message")
	`HMBP_ASSERT_SAME(a_err_word, tx.valid && tx.parse_status == ST_ERROR, tx.token_kind == KIND_DELIM && tx.body_length == '0 && !tx.token_start, "error word not blank")
	`HMBP_ASSERT_NEXT(a_word_out, accept, tx.valid, "accepted byte gave no word")
	`HMBP_ASSERT_SAME(a_body_rem, phase_q == PH_BODY || phase_q == PH_CDATA, rem_q != '0, "body phase with nothing remaining")

endmodule

@@ tb/tb_http_message_byte_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_http_message_byte_parser
// Streams whole requests (plain, content-length, chunked), corrupted requests
// and random noise through the parser. A cycle-free tagger in the bench
// predicts each result word. The bench compares every word field by field
// across several capacity settings and backpressure mixes.
// ---------------------------------------------------------------------------
module tb_http_message_byte_parser;
	import hmbp_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       nm;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  tb;
		kind_t       kind;
		logic        st;
		status_t     status;
		logic [31:0] blen;
	} tag_word_t;

	logic clk = 1'b0;
	logic arst_n;

	hmbp_in_if  rx_ch();
	hmbp_out_if tx_ch();
	hmbp_cfg_if cfg_ch();

	http_message_byte_parser uut (
		.clk(clk), .arst_n(arst_n), .rx(rx_ch), .tx(tx_ch), .cfg(cfg_ch)
	);

	// Free-running clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	in_word_t  pending_bytes[$];
	tag_word_t expected_tags[$];
	logic [7:0] msg[$];
	int src_idle, snk_stall;
	int n_errors, n_bytes, n_words, n_done, n_perr;
	bit need_restart;

	// Tagger state
	phase_t          t_phase;
	logic [31:0]     t_pos, t_cap;
	int              t_hdrs, t_kidx;
	logic [1:0]      t_kflags;
	logic [2:0]      t_seen;
	logic [3:0]      t_cmatch;
	longint unsigned t_len, t_rem;
	logic            t_err;

	localparam string LEN_KEY = "content-length";
	localparam string ENC_KEY = "transfer-encoding";
	localparam string CHUNKED = "chunked";

	function automatic logic is_sep(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
	endfunction

	function automatic int hex_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return 16;
	endfunction

	function automatic void restart_msg();
		t_phase = PH_LSTART;
		t_pos = 0;
		t_hdrs = 0;
		t_kidx = 0;
		t_kflags = 2'b11;
		t_seen = 0;
		t_cmatch = 0;
		t_len = 0;
		t_rem = 0;
	endfunction

	// Shift a digit into the length, mark it invalid on bad digit or overflow
	function automatic void shift_digit(input int base, input int d);
		longint unsigned lim;
		lim = 64'hFFFF_FFFF;
		if (t_seen[2]) return;
		if (d >= base || t_len > (lim - d) / base) t_seen[2] = 1'b1;
		else t_len = t_len * base + d;
	endfunction

	function automatic void match_key(input logic [7:0] c);
		if (t_kidx >= 14 || c != LEN_KEY[t_kidx]) t_kflags[0] = 1'b0;
		if (t_kidx >= 17 || c != ENC_KEY[t_kidx]) t_kflags[1] = 1'b0;
		if (t_kidx < 31) t_kidx++;
	endfunction

	function automatic void close_key();
		logic [1:0] f;
		f = 0;
		if (t_kflags[0] && t_kidx == 14 && !t_seen[0]) f[0] = 1'b1;
		if (t_kflags[1] && t_kidx == 17 && !t_seen[1]) f[1] = 1'b1;
		t_kflags = f;
	endfunction

	function automatic void match_value(input logic [7:0] c);
		int i;
		if (t_kflags[0]) shift_digit(10, (c >= "0" && c <= "9") ? c - "0" : 10);
		if (t_kflags[1]) begin
			i = t_cmatch[2:0];
			if (i < 7) begin
				if (c != CHUNKED[i]) t_cmatch[3] = 1'b1;
				t_cmatch[2:0] = 3'(i + 1);
			end
		end
	endfunction

	// Tag one byte and advance the tagger
	function automatic tag_word_t tag_byte(input logic [7:0] c, input logic nm);
		tag_word_t w;
		logic fail, done, cr, lf, st;
		logic [3:0] kind;
		logic [7:0] tb;
		logic [31:0] blen;
		tb = c; kind = KIND_DELIM; st = 0; fail = 0; done = 0; blen = 0;
		cr = c == CH_CR;
		lf = c == CH_LF;
		if (nm) begin
			restart_msg();
			t_err = 0;
		end
		if (t_err) begin
			w = '{c, KIND_DELIM, 1'b0, ST_ERROR, 32'd0};
			return w;
		end
		if (t_pos != 32'hFFFF_FFFF) t_pos++;
		case (t_phase)
			PH_LSTART, PH_PRE_TARGET: begin
				if (!is_sep(c)) begin
					if (cr || lf) fail = 1;
					else begin
						st = 1;
						kind = (t_phase == PH_LSTART) ? KIND_METHOD : KIND_TARGET;
						t_phase = (t_phase == PH_LSTART) ? PH_METHOD : PH_TARGET;
					end
				end
			end
			PH_METHOD, PH_TARGET: begin
				if (cr || lf) fail = 1;
				else if (is_sep(c)) t_phase = (t_phase == PH_METHOD) ? PH_PRE_TARGET : PH_PRE_VER;
				else kind = (t_phase == PH_METHOD) ? KIND_METHOD : KIND_TARGET;
			end
			PH_PRE_VER, PH_VER: begin
				if (!(t_phase == PH_PRE_VER && is_sep(c))) begin
					if (lf) fail = 1;
					else if (cr) t_phase = PH_LINE_LF;
					else begin
						st = t_phase == PH_PRE_VER;
						kind = KIND_VER;
						t_phase = PH_VER;
					end
				end
			end
			PH_LINE_LF: begin
				if (!lf) fail = 1;
				else t_phase = PH_HSTART;
			end
			PH_HSTART, PH_KEY: begin
				if (!(t_phase == PH_HSTART && is_sep(c))) begin
					if (t_phase == PH_KEY && cr) fail = 1;
					else if (lf) fail = 1;
					else if (cr) t_phase = PH_END_LF;
					else begin
						if (t_phase == PH_HSTART) begin
							t_kidx = 0;
							t_kflags = 2'b11;
						end
						if (c == CH_COLON) begin
							close_key();
							t_phase = PH_PRE_VAL;
						end else begin
							if (c >= CH_UP_A && c <= CH_UP_Z) tb = c + LOWER_OFS;
							match_key(tb);
							kind = KIND_KEY;
							st = t_phase == PH_HSTART;
							t_phase = PH_KEY;
						end
					end
				end
			end
			PH_PRE_VAL, PH_VAL: begin
				if (!(t_phase == PH_PRE_VAL && is_sep(c))) begin
					if (lf) fail = 1;
					else if (cr) t_phase = PH_HDR_LF;
					else begin
						match_value(c);
						kind = KIND_VALUE;
						st = t_phase == PH_PRE_VAL;
						t_phase = PH_VAL;
					end
				end
			end
			PH_HDR_LF: begin
				if (!lf || t_hdrs >= MAX_HEADERS) fail = 1;
				else begin
					t_hdrs++;
					t_seen[1:0] = t_seen[1:0] | t_kflags;
					t_kflags = 2'b11;
					t_kidx = 0;
					t_phase = PH_HSTART;
				end
			end
			PH_END_LF: begin
				if (!lf) fail = 1;
				else if (t_seen[0]) begin
					if (t_seen[2] || t_len > 64'(t_cap) || 64'(t_pos) > 64'(t_cap) - t_len) fail = 1;
					else if (t_len == 0) done = 1;
					else begin
						t_rem = t_len;
						t_phase = PH_BODY;
					end
				end else if (t_seen[1]) begin
					if (t_cmatch[3]) fail = 1;
					else begin
						t_len = 0;
						t_seen[2] = 1'b0;
						t_phase = PH_CSIZE_START;
					end
				end else done = 1;
			end
			PH_BODY, PH_CDATA: begin
				kind = KIND_BODY;
				st = t_rem == t_len;
				if (t_rem > 0) t_rem--;
				if (t_rem == 0) begin
					if (t_phase == PH_BODY) begin
						blen = t_len[31:0];
						done = 1;
					end else t_phase = PH_CDATA_CR;
				end
			end
			PH_CSIZE_START: begin
				if (is_sep(c) || cr || lf || c == CH_SEMI) fail = 1;
				else begin
					shift_digit(16, hex_of(c));
					kind = KIND_CSIZE;
					st = 1;
					t_phase = PH_CSIZE;
				end
			end
			PH_CSIZE: begin
				if (lf) fail = 1;
				else if (cr) t_phase = PH_CSIZE_LF;
				else if (is_sep(c) || c == CH_SEMI) begin
					kind = KIND_CEXT;
					st = 1;
					t_phase = PH_CEXT;
				end else begin
					shift_digit(16, hex_of(c));
					kind = KIND_CSIZE;
				end
			end
			PH_CEXT: begin
				if (lf) fail = 1;
				else if (cr) t_phase = PH_CSIZE_LF;
				else kind = KIND_CEXT;
			end
			PH_CSIZE_LF: begin
				if (!lf || t_seen[2]) fail = 1;
				else begin
					t_rem = t_len;
					t_phase = (t_len == 0) ? PH_CDATA_CR : PH_CDATA;
				end
			end
			PH_CDATA_CR: begin
				if (!cr) fail = 1;
				else t_phase = PH_CDATA_LF;
			end
			PH_CDATA_LF: begin
				if (!lf) fail = 1;
				else begin
					blen = t_len[31:0];
					done = 1;
				end
			end
			default: fail = 1;
		endcase

		w.status = ST_BUSY;
		if (fail) begin
			t_err = 1;
			w.status = ST_ERROR;
			kind = KIND_DELIM; st = 0; blen = 0; tb = c;
		end else if (done) begin
			w.status = ST_DONE;
			restart_msg();
		end else if (t_phase inside {PH_BODY, PH_CDATA, PH_CDATA_CR, PH_CDATA_LF}) begin
			blen = t_len[31:0];
		end
		w.tb = tb;
		w.kind = kind_t'(kind);
		w.st = st;
		w.blen = blen;
		return w;
	endfunction

	// Byte driver: launch pending bytes, tag each accepted one
	always @(posedge clk) begin
		in_word_t it;
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.data_byte <= 8'd0;
			rx_ch.new_message <= 1'b0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				expected_tags.push_back(tag_byte(rx_ch.data_byte, rx_ch.new_message));
				n_bytes++;
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle) begin
					it = pending_bytes.pop_front();
					rx_ch.valid <= 1'b1;
					rx_ch.data_byte <= it.b;
					rx_ch.new_message <= it.nm;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Word monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		tag_word_t e;
		if (!arst_n) begin
			tx_ch.ready <= 1'b0;
		end else begin
			if (tx_ch.valid && tx_ch.ready) begin
				n_words++;
				if (expected_tags.size() == 0) begin
					$error("unexpected word, tagged_byte %0h", tx_ch.tagged_byte);
					n_errors++;
				end else begin
					e = expected_tags.pop_front();
					if (e.status == ST_DONE) n_done++;
					if (e.status == ST_ERROR) n_perr++;
					if (tx_ch.tagged_byte !== e.tb) begin
						$error("tagged_byte expected %0h got %0h", e.tb, tx_ch.tagged_byte);
						n_errors++;
					end
					if (tx_ch.token_kind !== e.kind) begin
						$error("token_kind expected %0d got %0d", e.kind, tx_ch.token_kind);
						n_errors++;
					end
					if (tx_ch.token_start !== e.st) begin
						$error("token_start expected %0d got %0d", e.st, tx_ch.token_start);
						n_errors++;
					end
					if (tx_ch.parse_status !== e.status) begin
						$error("parse_status expected %0d got %0d", e.status, tx_ch.parse_status);
						n_errors++;
					end
					if (tx_ch.body_length !== e.blen) begin
						$error("body_length expected %0d got %0d", e.blen, tx_ch.body_length);
						n_errors++;
					end
				end
			end
			tx_ch.ready <= ($urandom_range(99) >= snk_stall);
		end
	end

	function automatic void put(input string s);
		foreach (s[i]) msg.push_back(s[i]);
	endfunction

	function automatic void put_sep();
		logic [7:0] seps[4];
		seps = '{CH_SP, CH_TAB, CH_VT, CH_FF};
		msg.push_back(seps[$urandom_range(3)]);
	endfunction

	function automatic string mixed_case(input string s);
		string r;
		r = s;
		foreach (r[i]) if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1)) r[i] = r[i] - 32;
		return r;
	endfunction

	function automatic string rnd_token(input int n);
		string r;
		r = "";
		repeat (n) r = {r, string'(8'($urandom_range(8'h61, 8'h7A)))};
		return mixed_case(r);
	endfunction

	// Queue the built message; restart on its first byte when needed
	function automatic void commit(input logic nm);
		foreach (msg[i]) pending_bytes.push_back('{msg[i], (i == 0) ? nm : 1'b0});
		msg.delete();
	endfunction

	function automatic void filler_header();
		put(rnd_token($urandom_range(1, 6)));
		put(":");
		if ($urandom_range(1)) put_sep();
		if ($urandom_range(3)) put(rnd_token($urandom_range(1, 8)));
		put("\r\n");
	endfunction

	// Build one request: 0 no body, 1 content-length, 2 chunked
	function automatic void build_request(input int form);
		int n;
		string h;
		msg.delete();
		put(rnd_token($urandom_range(1, 6)));
		put_sep();
		put({"/", rnd_token($urandom_range(0, 5))});
		put_sep();
		if ($urandom_range(7)) put("HTTP/1.1");
		put("\r\n");
		repeat ($urandom_range(0, 2)) filler_header();
		if (form == 1) begin
			n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
			put({mixed_case(LEN_KEY), ":"});
			put_sep();
			put($sformatf("%0d\r\n", n));
			if ($urandom_range(4) == 0) put({LEN_KEY, ": 3\r\n"});
		end else if (form == 2) begin
			n = $urandom_range(0, 20);
			put({mixed_case(ENC_KEY), ": "});
			case ($urandom_range(9))
				0: put("Chunked");
				1: put("chunk");
				2: put("gzip");
				default: put(CHUNKED);
			endcase
			put("\r\n");
		end
		repeat ($urandom_range(0, 2)) filler_header();
		put("\r\n");
		if (form == 1) begin
			repeat (n) msg.push_back(8'($urandom_range(255)));
		end else if (form == 2) begin
			h = mixed_case($sformatf("%0h", n));
			if ($urandom_range(3) == 0) h = {"0", h};
			put(h);
			if ($urandom_range(2) == 0) begin
				if ($urandom_range(1)) put(";");
				else put_sep();
				put("x=y");
			end
			put("\r\n");
			repeat (n) msg.push_back(8'($urandom_range(255)));
			put("\r\n");
		end
	endfunction

	// Mostly well-formed requests, some corrupted or cut short, some noise
	task automatic random_traffic(input int n_target);
		int start, sel, idx;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < n_target) begin
			sel = $urandom_range(99);
			if (sel < 8) begin
				repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(255)));
				commit($urandom_range(1));
				need_restart = 1;
			end else begin
				build_request($urandom_range(2));
				if (sel < 23) begin
					idx = $urandom_range(msg.size() - 1);
					if ($urandom_range(1)) msg[idx] = 8'($urandom_range(255));
					else while (msg.size() > idx + 1) void'(msg.pop_back());
				end
				commit(need_restart || $urandom_range(4) == 0);
				need_restart = sel < 23;
			end
		end
	endtask

	task automatic drain();
		while (pending_bytes.size() > 0 || rx_ch.valid || expected_tags.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [31:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		t_cap = v;
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] caps[4];
		int srcs[5], snks[5];
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.data_byte = 8'd0;
		rx_ch.new_message = 1'b0;
		tx_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 32'd0;
		n_errors = 0; n_bytes = 0; n_words = 0; n_done = 0; n_perr = 0;
		need_restart = 0;
		src_idle = 0; snk_stall = 0;
		t_cap = CAP_RESET;
		t_err = 0;
		restart_msg();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset capacity
		put("GET / HTTP/1.1\r\n\r\n"); commit(1);
		put("\tPOST\x0b/a\x0cHTTP/1.1\r\nContent-Length: 5\r\nHost:x\r\n\r\nAB\r\nZ");
		commit(0);
		put("PUT /z V\r\ncontent-length:0\r\n\r\n"); commit(0);
		put("P /c H\r\nTransfer-Encoding: chunked\r\n\r\n1aF;ext\r\n");
		repeat (431) msg.push_back(8'hFF);
		put("\r\n"); commit(0);
		put("P /c H\r\ntransfer-encoding: chunked\r\n\r\n0\r\n\r\n"); commit(0);
		put("P /c H\r\ntransfer-encoding: chunked\r\n\r\n1g\r\n"); commit(0);
		put("P /c H\r\ntransfer-encoding: chunked\r\n\r\nFFFFFFFFF\r\n"); commit(1);
		put("P /c H\r\ncontent-length: 99999999999\r\n\r\n"); commit(1);
		put("P /c H\r\ncontent-length: 70000\r\n\r\n"); commit(1);
		put("P /c H\r\n");
		repeat (33) put("a:b\r\n");
		commit(1);
		put("G\r"); commit(1);
		put("G / H\n"); commit(1);
		put("G / H\r\nnocolon\r\n"); commit(1);
		put("G / H\r\n\r"); put("x"); commit(1);
		random_traffic(170);
		drain();

		// Remaining phases: capacity and backpressure mixes
		caps = '{32'd1, 32'hFFFF_FFFF, 32'($urandom_range(20, 120)), CAP_RESET};
		srcs = '{0, 75, 0, 34, 0};
		snks = '{0, 0, 75, 34, 0};
		for (int p = 0; p < 4; p++) begin
			write_capacity(caps[p]);
			src_idle = srcs[p + 1];
			snk_stall = snks[p + 1];
			need_restart = 1;
			random_traffic(170);
			drain();
		end

		$display("tb_http_message_byte_parser: %0d bytes tagged, %0d words checked", n_bytes,
			n_words);
		$display("  %0d messages completed, %0d error words, 5 capacity/stall mixes", n_done,
			n_perr);
		if (n_errors == 0)
			$display("tb_http_message_byte_parser: done, clean");
		else
			$display("tb_http_message_byte_parser: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("tb_http_message_byte_parser: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/hmbp_pkg.sv
hdl/hmbp_if.sv
hdl/http_message_byte_parser.sv
tb/tb_http_message_byte_parser.sv
